// ----- src/mbtt_pkg.sv -----
package mbtt_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int SLOT_W = 6;
    localparam logic [31:0] TIMEOUT_RESET = 32'd3000;
    localparam logic [15:0] RETRY_RESET = 16'd100;
    localparam logic [15:0] TR_WRAP = 16'd65534;

    typedef enum logic [1:0] {
        OP_SUBMIT = 2'd0,
        OP_RESP   = 2'd1,
        OP_TICK   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        K_NONE   = 3'd0,
        K_SEND   = 3'd1,
        K_RETX   = 3'd2,
        K_GIVEUP = 3'd3,
        K_POS    = 3'd4,
        K_NEG    = 3'd5,
        K_FULL   = 3'd6,
        K_DUP    = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        CFG_TIMEOUT = 2'd0,
        CFG_RETRY   = 2'd1,
        CFG_ADDR    = 2'd2,
        CFG_PORT    = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_AGE,
        S_FINISH,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture input word, clear scan
        logic clr_idx;  // restart slot walk
        logic step;     // examine one slot, advance
        logic age;      // age one slot, advance
        logic finish;   // form result, update table
        logic out_done; // result taken
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;     // walk at final slot
        logic is_tick;
    } t_stat;

    typedef struct packed {
        logic [2:0]  kind;
        logic [5:0]  slot;
        logic [15:0] tr;
        logic [15:0] len;
        logic [7:0]  unit;
        logic [7:0]  fn;
        logic [15:0] addr;
        logic [15:0] cnt;
        logic [31:0] dst_addr;
        logic [15:0] dst_port;
    } t_result;

endpackage

// ----- src/mbtt_ctrl.sv -----
module mbtt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_fire,
    input  logic           i_out_fire,
    input  mbtt_pkg::t_stat i_stat,
    output mbtt_pkg::t_cmd  o_cmd,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output logic           o_idle
);
    import mbtt_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        o_idle = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_idle = 1'b1;
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_stat.last) begin
                    o_cmd.clr_idx = 1'b1;
                    n_state = i_stat.is_tick ? S_AGE : S_FINISH;
                end
            end
            S_AGE: begin
                o_cmd.age = 1'b1;
                if (i_stat.last) n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_fire) begin
                    o_cmd.out_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ----- src/mbtt_dp.sv -----
module mbtt_dp #(
    parameter int TABLE_DEPTH = mbtt_pkg::DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mbtt_pkg::t_cmd   i_cmd,
    output mbtt_pkg::t_stat  o_stat,
    input  logic             i_cfg_fire,
    input  logic [1:0]       i_cfg_idx,
    input  logic [31:0]      i_cfg_data,
    input  logic [1:0]       i_opcode,
    input  logic [7:0]       i_unit_id,
    input  logic [7:0]       i_fcode,
    input  logic [15:0]      i_first_reg,
    input  logic [15:0]      i_num_regs,
    input  logic [15:0]      i_transaction,
    input  logic [15:0]      i_protocol,
    input  logic [7:0]       i_rx_fcode,
    input  logic [7:0]       i_rx_byte1,
    input  logic [7:0]       i_rx_byte2,
    input  logic [7:0]       i_rx_byte3,
    input  logic [7:0]       i_rx_byte4,
    output mbtt_pkg::t_result o_result,
    output logic [$clog2(TABLE_DEPTH+1)-1:0] o_used
);
    import mbtt_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);

    logic [31:0] r_timeout, r_srv_addr;
    logic [15:0] r_retry, r_srv_port;

    logic [TABLE_DEPTH-1:0] r_use;
    logic [15:0] r_e_tr   [TABLE_DEPTH];
    logic [7:0]  r_e_fn   [TABLE_DEPTH];
    logic [15:0] r_e_addr [TABLE_DEPTH];
    logic [15:0] r_e_cnt  [TABLE_DEPTH];
    logic [7:0]  r_e_unit [TABLE_DEPTH];
    logic [15:0] r_e_len  [TABLE_DEPTH];
    logic [47:0] r_e_srv  [TABLE_DEPTH];
    logic [31:0] r_e_wait [TABLE_DEPTH];
    logic [15:0] r_e_ret  [TABLE_DEPTH];

    logic [IW-1:0] r_head, r_scan, r_idx;
    logic [CW-1:0] r_used;
    logic [15:0] r_next_tr;

    // captured word
    logic [1:0]  r_op;
    logic [7:0]  r_unit, r_fn, r_rx, r_b1, r_b2, r_b3, r_b4;
    logic [15:0] r_addr, r_cnt, r_tr, r_proto, r_my_tr;

    // scan results
    logic r_hit, r_free_found;
    logic [IW-1:0] r_hit_idx, r_free_idx;

    t_result r_res;

    logic [15:0] w_tr_inc, w_len;
    logic        w_match;
    logic [IW-1:0] w_s;
    logic        w_head_ok, w_timeout, w_give;
    logic [15:0] w_ret_inc;
    logic [15:0] w_raddr, w_rcnt;
    logic [2:0]  w_rkind;

    assign w_tr_inc = r_next_tr + 16'd1;

    always_comb begin
        if (r_fn == 8'd3 || r_fn == 8'd6) w_len = 16'd6;
        else if (r_fn == 8'd16) w_len = 16'd6 + {r_cnt[14:0], 1'b0};
        else w_len = 16'd1;
    end

    // per-slot comparison at the walk index
    always_comb begin
        if (r_op == OP_SUBMIT)
            w_match = r_use[r_idx] && r_e_fn[r_idx] == r_fn && r_e_addr[r_idx] == r_addr
                      && r_e_cnt[r_idx] == r_cnt;
        else
            w_match = r_use[r_idx] && r_e_tr[r_idx] == r_tr;
    end

    assign w_head_ok = !r_use[r_head];
    assign w_s = (r_op == OP_SUBMIT) ? (w_head_ok ? r_head : r_free_idx)
               : (r_op == OP_RESP) ? r_hit_idx : r_scan;
    assign w_timeout = r_use[r_scan] && r_e_wait[r_scan] >= r_timeout;
    assign w_ret_inc = (r_e_ret[r_scan] != 16'hFFFF) ? r_e_ret[r_scan] + 16'd1
                                                     : r_e_ret[r_scan];
    assign w_give = w_ret_inc >= r_retry;

    always_comb begin
        if (r_rx == 8'd6 || r_rx == 8'd16) w_raddr = {r_b1, r_b2};
        else w_raddr = r_e_addr[r_hit_idx];
        if (r_rx == 8'd3) w_rcnt = {9'd0, r_b1[7:1]};
        else if (r_rx == 8'd6) w_rcnt = 16'd1;
        else if (r_rx == 8'd16) w_rcnt = {r_b3, r_b4};
        else w_rcnt = 16'd0;
        if (r_proto == 16'd0 && (r_e_fn[r_hit_idx] == r_rx ||
                                 r_e_fn[r_hit_idx] == {1'b0, r_rx[6:0]}))
            w_rkind = K_POS;
        else
            w_rkind = K_NEG;
    end

    assign o_stat.last = (r_idx == LAST);
    assign o_stat.is_tick = (r_op == OP_TICK);
    assign o_result = r_res;
    assign o_used = r_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_retry <= RETRY_RESET;
            r_srv_addr <= '0;
            r_srv_port <= '0;
        end else if (i_cfg_fire) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TIMEOUT: r_timeout <= i_cfg_data;
                CFG_RETRY:   r_retry <= i_cfg_data[15:0];
                CFG_ADDR:    r_srv_addr <= i_cfg_data;
                CFG_PORT:    r_srv_port <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // control state of the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use <= '0;
            r_head <= '0;
            r_scan <= '0;
            r_used <= '0;
            r_next_tr <= 16'd1;
            r_idx <= '0;
            r_hit <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
                r_hit <= 1'b0;
                r_free_found <= 1'b0;
                if (t_op'(i_opcode) == OP_SUBMIT) begin
                    r_next_tr <= (w_tr_inc >= TR_WRAP || w_tr_inc == 16'd0) ? 16'd1
                                                                            : w_tr_inc;
                end
            end
            if (i_cmd.clr_idx) r_idx <= '0;
            else if (i_cmd.step || i_cmd.age) r_idx <= (r_idx == LAST) ? '0 : r_idx + IW'(1);
            if (i_cmd.step) begin
                if (w_match && !r_hit) r_hit <= 1'b1;
                if (!r_use[r_idx] && !r_free_found) r_free_found <= 1'b1;
            end
            if (i_cmd.finish) begin
                unique case (t_op'(r_op))
                    OP_SUBMIT: begin
                        if (r_used < CW'(TABLE_DEPTH) && !r_hit &&
                            (w_head_ok || r_free_found)) begin
                            r_use[w_s] <= 1'b1;
                            r_used <= r_used + CW'(1);
                            r_head <= (w_s == LAST) ? '0 : w_s + IW'(1);
                        end
                    end
                    OP_RESP: begin
                        if (r_hit && r_proto == 16'd0) begin
                            r_use[r_hit_idx] <= 1'b0;
                            r_used <= r_used - CW'(1);
                        end
                    end
                    OP_TICK: begin
                        if (w_timeout && w_give) begin
                            r_use[r_scan] <= 1'b0;
                            r_used <= r_used - CW'(1);
                        end
                        r_scan <= (r_scan == LAST) ? '0 : r_scan + IW'(1);
                    end
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_opcode;
            r_unit <= i_unit_id;
            r_fn <= i_fcode;
            r_addr <= i_first_reg;
            r_cnt <= i_num_regs;
            r_tr <= i_transaction;
            r_proto <= i_protocol;
            r_rx <= i_rx_fcode;
            r_b1 <= i_rx_byte1;
            r_b2 <= i_rx_byte2;
            r_b3 <= i_rx_byte3;
            r_b4 <= i_rx_byte4;
            r_my_tr <= r_next_tr;
        end
        if (i_cmd.step) begin
            if (w_match && !r_hit) r_hit_idx <= r_idx;
            if (!r_use[r_idx] && !r_free_found) r_free_idx <= r_idx;
        end
        if (i_cmd.age && r_use[r_idx] && r_e_wait[r_idx] != 32'hFFFF_FFFF)
            r_e_wait[r_idx] <= r_e_wait[r_idx] + 32'd1;
        if (i_cmd.finish) begin
            unique case (t_op'(r_op))
                OP_SUBMIT: begin
                    if (r_used >= CW'(TABLE_DEPTH) || (!r_hit && !w_head_ok
                                                       && !r_free_found)) begin
                        r_res <= '{K_FULL, 6'd0, r_my_tr, w_len, r_unit, r_fn, r_addr,
                                   r_cnt, r_srv_addr, r_srv_port};
                    end else if (r_hit) begin
                        r_res <= '{K_DUP, 6'(r_hit_idx), r_my_tr, w_len, r_unit, r_fn,
                                   r_addr, r_cnt, r_srv_addr, r_srv_port};
                    end else begin
                        r_e_tr[w_s] <= r_my_tr;
                        r_e_fn[w_s] <= r_fn;
                        r_e_addr[w_s] <= r_addr;
                        r_e_cnt[w_s] <= r_cnt;
                        r_e_unit[w_s] <= r_unit;
                        r_e_len[w_s] <= w_len;
                        r_e_srv[w_s] <= {r_srv_addr, r_srv_port};
                        r_e_wait[w_s] <= '0;
                        r_e_ret[w_s] <= '0;
                        r_res <= '{K_SEND, 6'(w_s), r_my_tr, w_len, r_unit, r_fn, r_addr,
                                   r_cnt, r_srv_addr, r_srv_port};
                    end
                end
                OP_RESP: begin
                    if (r_hit)
                        r_res <= '{w_rkind, 6'(r_hit_idx), r_e_tr[r_hit_idx],
                                   r_e_len[r_hit_idx], r_e_unit[r_hit_idx], r_rx, w_raddr,
                                   w_rcnt, r_e_srv[r_hit_idx][47:16],
                                   r_e_srv[r_hit_idx][15:0]};
                    else
                        r_res <= '0;
                end
                OP_TICK: begin
                    if (w_timeout) begin
                        r_e_ret[r_scan] <= w_ret_inc;
                        r_e_wait[r_scan] <= '0;
                        r_res <= '{w_give ? K_GIVEUP : K_RETX, 6'(r_scan), r_e_tr[r_scan],
                                   r_e_len[r_scan], r_e_unit[r_scan], r_e_fn[r_scan],
                                   r_e_addr[r_scan], r_e_cnt[r_scan],
                                   r_e_srv[r_scan][47:16], r_e_srv[r_scan][15:0]};
                    end else begin
                        r_res <= '0;
                    end
                end
                default: r_res <= '0;
            endcase
        end
    end
endmodule

// ----- src/modbus_tcp_transaction_tracker_core.sv -----
// Modbus TCP transaction table. Each word is accepted in the idle state; a walk over every
// slot then does the match / duplicate / free-slot search, a second walk ages the slots for
// a tick, then the table is updated and the result is presented. One word is in flight at a
// time; results hold until taken.
module modbus_tcp_transaction_tracker_core #(
    parameter int TABLE_DEPTH = mbtt_pkg::DEPTH_DEFAULT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode[1:0] unit_id[9:2] fcode[17:10] first_reg[33:18] num_regs[49:34]
    // transaction[65:50] protocol[81:66] rx_fcode[89:82] rx_byte1[97:90]
    // rx_byte2[105:98] rx_byte3[113:106] rx_byte4[121:114], zero fill to 128
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // slot[5:0] out_transaction[21:6] length[37:22] out_unit_id[45:38]
    // out_fcode[53:46] out_first_reg[69:54] out_num_regs[85:70]
    // dest_address[117:86] dest_port[133:118], zero fill to 136
    output logic [135:0] m_axis_tdata,
    // kind[2:0]
    output logic [2:0]   m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import mbtt_pkg::*;

    t_cmd    w_cmd;
    t_stat   w_stat;
    t_result w_res;
    logic    w_idle;
    logic [$clog2(TABLE_DEPTH+1)-1:0] w_used;

    assign o_cfg_ready = 1'b1;

    mbtt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_fire(s_axis_tvalid && s_axis_tready),
        .i_out_fire(m_axis_tvalid && m_axis_tready),
        .i_stat(w_stat), .o_cmd(w_cmd),
        .o_in_ready(s_axis_tready), .o_out_valid(m_axis_tvalid), .o_idle(w_idle)
    );

    mbtt_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_cfg_fire(i_cfg_valid && o_cfg_ready), .i_cfg_idx(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_opcode(s_axis_tdata[1:0]), .i_unit_id(s_axis_tdata[9:2]),
        .i_fcode(s_axis_tdata[17:10]), .i_first_reg(s_axis_tdata[33:18]),
        .i_num_regs(s_axis_tdata[49:34]), .i_transaction(s_axis_tdata[65:50]),
        .i_protocol(s_axis_tdata[81:66]), .i_rx_fcode(s_axis_tdata[89:82]),
        .i_rx_byte1(s_axis_tdata[97:90]), .i_rx_byte2(s_axis_tdata[105:98]),
        .i_rx_byte3(s_axis_tdata[113:106]), .i_rx_byte4(s_axis_tdata[121:114]),
        .o_result(w_res), .o_used(w_used)
    );

    assign m_axis_tuser = w_res.kind;
    assign m_axis_tdata = {2'b00, w_res.dst_port, w_res.dst_addr, w_res.cnt, w_res.addr,
                           w_res.fn, w_res.unit, w_res.len, w_res.tr, w_res.slot};

    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_used <= ($clog2(TABLE_DEPTH+1))'(TABLE_DEPTH))
        else $error("used count beyond table depth");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> w_idle)
        else $error("not idle after result taken");
endmodule

// ----- tb/sv/modbus_tcp_transaction_tracker_core_tb.sv -----
`timescale 1ns / 1ps

module modbus_tcp_transaction_tracker_core_tb;
    import mbtt_pkg::*;

    localparam int DEPTH = DEPTH_DEFAULT;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  unit;
        logic [7:0]  fn;
        logic [15:0] addr;
        logic [15:0] cnt;
        logic [15:0] tr;
        logic [15:0] proto;
        logic [7:0]  rx;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [7:0]  b4;
    } t_word;

    typedef struct {
        t_word   w;
        bit      fixed;
        t_result r;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    modbus_tcp_transaction_tracker_core #(.TABLE_DEPTH(DEPTH)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // shadow of the transaction table
    logic [31:0] tt_timeout;
    logic [15:0] tt_retry_lim;
    logic [31:0] tt_srv_addr;
    logic [15:0] tt_srv_port;
    logic        tt_busy [DEPTH];
    logic [15:0] tt_tr [DEPTH];
    logic [7:0]  tt_fn [DEPTH];
    logic [15:0] tt_addr [DEPTH];
    logic [15:0] tt_cnt [DEPTH];
    logic [7:0]  tt_unit [DEPTH];
    logic [15:0] tt_len [DEPTH];
    logic [31:0] tt_dst [DEPTH];
    logic [15:0] tt_dport [DEPTH];
    logic [31:0] tt_wait [DEPTH];
    logic [15:0] tt_retries [DEPTH];
    int          tt_head, tt_scan, tt_used;
    logic [15:0] tt_next_tr;

    t_result pending_results [$];
    int      n_err;
    int      burst_left;
    bit      no_gaps;
    bit      hold_go;
    bit      hold_done;
    int      hold_cnt;
    int      rx_mode, rx_mode_left;
    t_row    rows [24];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_word mk_sub(logic [7:0] unit, logic [7:0] fn, logic [15:0] addr,
                                     logic [15:0] cnt);
        t_word w;
        w = '0;
        w.op = OP_SUBMIT;
        w.unit = unit;
        w.fn = fn;
        w.addr = addr;
        w.cnt = cnt;
        return w;
    endfunction

    function automatic t_word mk_rsp(logic [15:0] tr, logic [15:0] proto, logic [7:0] rx,
                                     logic [7:0] b1, logic [7:0] b2, logic [7:0] b3,
                                     logic [7:0] b4);
        t_word w;
        w = '0;
        w.op = OP_RESP;
        w.tr = tr;
        w.proto = proto;
        w.rx = rx;
        w.b1 = b1;
        w.b2 = b2;
        w.b3 = b3;
        w.b4 = b4;
        return w;
    endfunction

    function automatic t_word mk_op(t_op op);
        t_word w;
        w = '0;
        w.op = op;
        return w;
    endfunction

    task automatic table_reset();
        tt_timeout = TIMEOUT_RESET;
        tt_retry_lim = RETRY_RESET;
        tt_srv_addr = '0;
        tt_srv_port = '0;
        for (int i = 0; i < DEPTH; i++) tt_busy[i] = 1'b0;
        tt_head = 0;
        tt_scan = 0;
        tt_used = 0;
        tt_next_tr = 16'd1;
    endtask

    function automatic t_result entry_result(t_kind k, int s);
        t_result r;
        r.kind = k;
        r.slot = SLOT_W'(s);
        r.tr = tt_tr[s];
        r.len = tt_len[s];
        r.unit = tt_unit[s];
        r.fn = tt_fn[s];
        r.addr = tt_addr[s];
        r.cnt = tt_cnt[s];
        r.dst_addr = tt_dst[s];
        r.dst_port = tt_dport[s];
        return r;
    endfunction

    // works out the result of one word and updates the shadow table
    task automatic track_word(input t_word w, output t_result r);
        logic [15:0] tr, len;
        int          s;
        bit          found;
        r = '0;
        case (w.op)
            OP_SUBMIT: begin
                tr = tt_next_tr;
                tt_next_tr = tt_next_tr + 16'd1;
                if (tt_next_tr >= TR_WRAP || tt_next_tr == 16'd0) tt_next_tr = 16'd1;
                if (w.fn == 8'd3 || w.fn == 8'd6) len = 16'd6;
                else if (w.fn == 8'd16) len = 16'd6 + {w.cnt[14:0], 1'b0};
                else len = 16'd1;
                r.tr = tr;
                r.len = len;
                r.unit = w.unit;
                r.fn = w.fn;
                r.addr = w.addr;
                r.cnt = w.cnt;
                r.dst_addr = tt_srv_addr;
                r.dst_port = tt_srv_port;
                if (tt_used >= DEPTH) begin
                    r.kind = K_FULL;
                    return;
                end
                for (int i = 0; i < DEPTH; i++) begin
                    if (tt_busy[i] && tt_fn[i] == w.fn && tt_addr[i] == w.addr &&
                        tt_cnt[i] == w.cnt) begin
                        r.kind = K_DUP;
                        r.slot = SLOT_W'(i);
                        return;
                    end
                end
                s = tt_head;
                found = !tt_busy[s];
                for (int i = 0; i < DEPTH && !found; i++) begin
                    if (!tt_busy[i]) begin
                        s = i;
                        found = 1;
                    end
                end
                tt_busy[s] = 1'b1;
                tt_tr[s] = tr;
                tt_fn[s] = w.fn;
                tt_addr[s] = w.addr;
                tt_cnt[s] = w.cnt;
                tt_unit[s] = w.unit;
                tt_len[s] = len;
                tt_dst[s] = tt_srv_addr;
                tt_dport[s] = tt_srv_port;
                tt_wait[s] = '0;
                tt_retries[s] = '0;
                tt_used++;
                tt_head = (s + 1 >= DEPTH) ? 0 : s + 1;
                r = entry_result(K_SEND, s);
            end
            OP_RESP: begin
                found = 0;
                s = 0;
                for (int i = 0; i < DEPTH && !found; i++) begin
                    if (tt_busy[i] && tt_tr[i] == w.tr) begin
                        s = i;
                        found = 1;
                    end
                end
                if (!found) return;
                r = entry_result(K_NEG, s);
                r.fn = w.rx;
                if (w.rx == 8'd6 || w.rx == 8'd16) r.addr = {w.b1, w.b2};
                if (w.rx == 8'd3) r.cnt = {9'd0, w.b1[7:1]};
                else if (w.rx == 8'd6) r.cnt = 16'd1;
                else if (w.rx == 8'd16) r.cnt = {w.b3, w.b4};
                else r.cnt = '0;
                if (w.proto == 16'd0) begin
                    if (tt_fn[s] == w.rx || tt_fn[s] == {1'b0, w.rx[6:0]}) r.kind = K_POS;
                    tt_busy[s] = 1'b0;
                    tt_used--;
                end
            end
            OP_TICK: begin
                for (int i = 0; i < DEPTH; i++)
                    if (tt_busy[i] && tt_wait[i] != '1) tt_wait[i]++;
                s = tt_scan;
                if (tt_busy[s] && tt_wait[s] >= tt_timeout) begin
                    if (tt_retries[s] != '1) tt_retries[s]++;
                    tt_wait[s] = '0;
                    if (tt_retries[s] >= tt_retry_lim) begin
                        r = entry_result(K_GIVEUP, s);
                        tt_busy[s] = 1'b0;
                        tt_used--;
                    end else begin
                        r = entry_result(K_RETX, s);
                    end
                end
                tt_scan = (s + 1 >= DEPTH) ? 0 : s + 1;
            end
            default: ;
        endcase
    endtask

    task automatic send_word(input t_word w);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, w.b4, w.b3, w.b2, w.b1, w.rx, w.proto, w.tr, w.cnt,
                         w.addr, w.fn, w.unit, w.op};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        if (!no_gaps) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 12);
                if ($urandom_range(0, 3) != 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 7)) @(posedge i_clk);
                end
            end
        end
    endtask

    task automatic push_word(input t_word w);
        t_result r;
        track_word(w, r);
        pending_results.push_back(r);
        send_word(w);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            CFG_TIMEOUT: tt_timeout = value;
            CFG_RETRY:   tt_retry_lim = value[15:0];
            CFG_ADDR:    tt_srv_addr = value;
            default:     tt_srv_port = value[15:0];
        endcase
    endtask

    task automatic setup(input logic [31:0] tmo, input logic [15:0] lim,
                         input logic [31:0] addr, input logic [15:0] port);
        drain();
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_RETRY, {16'd0, lim});
        write_reg(CFG_ADDR, addr);
        write_reg(CFG_PORT, {16'd0, port});
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] narrow16();
        return ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    endfunction

    // mostly well-formed traffic: responses aimed at pending entries
    function automatic t_word random_word();
        t_word w;
        int    live [$];
        int    pick, s;
        w = '0;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            case ($urandom_range(0, 4))
                0: w.fn = 8'd3;
                1: w.fn = 8'd6;
                2: w.fn = 8'd16;
                3: w.fn = 8'd3;
                default: w.fn = 8'($urandom);
            endcase
            w = mk_sub(8'($urandom), w.fn, narrow16(), narrow16());
        end else if (pick < 80) begin
            w = mk_rsp(16'($urandom), 16'd0, 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom));
            for (int i = 0; i < DEPTH; i++) if (tt_busy[i]) live.push_back(i);
            if (live.size() != 0 && $urandom_range(0, 9) < 8) begin
                s = live[$urandom_range(0, live.size() - 1)];
                w.tr = tt_tr[s];
                case ($urandom_range(0, 3))
                    0, 1: w.rx = tt_fn[s];
                    2: w.rx = tt_fn[s] | 8'h80;
                    default: ;
                endcase
            end
            if ($urandom_range(0, 7) == 0) w.proto = 16'($urandom_range(1, 65535));
        end else if (pick < 98) begin
            w = mk_op(OP_TICK);
        end else begin
            w = mk_op(OP_NOP);
        end
        return w;
    endfunction

    // receiver: own stall pattern, plus one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        hold_done = 0;
        hold_cnt = 0;
        rx_mode = 0;
        rx_mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_done) begin
                m_axis_tready <= 1'b0;
                hold_cnt++;
                if (hold_cnt >= HOLD_CYCLES) hold_done = 1;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode = $urandom_range(0, 2);
                    rx_mode_left = $urandom_range(16, 96);
                end
                rx_mode_left--;
                case (rx_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 1) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic chk(input string name, input logic [31:0] e, input logic [31:0] a);
        if (e !== a) begin
            $error("%s: expected %0h, got %0h", name, e, a);
            n_err++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected");
                n_err++;
            end else begin
                e = pending_results.pop_front();
                chk("kind", 32'(e.kind), 32'(m_axis_tuser));
                chk("slot", 32'(e.slot), 32'(m_axis_tdata[5:0]));
                chk("out_transaction", 32'(e.tr), 32'(m_axis_tdata[21:6]));
                chk("length", 32'(e.len), 32'(m_axis_tdata[37:22]));
                chk("out_unit_id", 32'(e.unit), 32'(m_axis_tdata[45:38]));
                chk("out_fcode", 32'(e.fn), 32'(m_axis_tdata[53:46]));
                chk("out_first_reg", 32'(e.addr), 32'(m_axis_tdata[69:54]));
                chk("out_num_regs", 32'(e.cnt), 32'(m_axis_tdata[85:70]));
                chk("dest_address", e.dst_addr, m_axis_tdata[117:86]);
                chk("dest_port", 32'(e.dst_port), 32'(m_axis_tdata[133:118]));
            end
        end
    end

    initial begin
        t_result r;
        int      waited;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_TIMEOUT;
        i_cfg_data = '0;
        n_err = 0;
        burst_left = 0;
        no_gaps = 0;
        hold_go = 0;
        table_reset();

        rows[0] = '{mk_op(OP_TICK), 1, '0};
        rows[1] = '{mk_rsp(16'd1, 16'd0, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0), 1, '0};
        rows[2] = '{mk_sub(8'hff, 8'd3, 16'd0, 16'd0), 1,
                    t_result'{K_SEND, 6'd0, 16'd1, 16'd6, 8'hff, 8'd3, 16'd0, 16'd0,
                              32'd0, 16'd0}};
        rows[3] = '{mk_sub(8'h00, 8'd6, 16'hffff, 16'hffff), 0, '0};
        rows[4] = '{mk_sub(8'h5a, 8'd16, 16'd1, 16'hffff), 0, '0};
        rows[5] = '{mk_sub(8'ha5, 8'hff, 16'd2, 16'd2), 0, '0};
        rows[6] = '{mk_sub(8'h11, 8'd3, 16'd0, 16'd0), 1,
                    t_result'{K_DUP, 6'd0, 16'd5, 16'd6, 8'h11, 8'd3, 16'd0, 16'd0,
                              32'd0, 16'd0}};
        // bad protocol keeps the entry pending
        rows[7] = '{mk_rsp(16'd1, 16'hffff, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0), 0, '0};
        rows[8] = '{mk_rsp(16'd1, 16'd0, 8'h83, 8'h10, 8'hff, 8'hff, 8'hff), 0, '0};
        rows[9] = '{mk_rsp(16'd2, 16'd0, 8'd6, 8'hab, 8'hcd, 8'h00, 8'h00), 0, '0};
        rows[10] = '{mk_rsp(16'd3, 16'd0, 8'd16, 8'h00, 8'hff, 8'h12, 8'h34), 0, '0};
        rows[11] = '{mk_rsp(16'd4, 16'd0, 8'h01, 8'hff, 8'h00, 8'hff, 8'h00), 0, '0};
        for (int i = 0; i < DEPTH; i++)
            rows[12 + i] = '{mk_sub(8'(i), 8'd3, 16'(100 + i), 16'(i)), 0, '0};
        rows[20] = '{mk_sub(8'h00, 8'd16, 16'hffff, 16'hffff), 1,
                     t_result'{K_FULL, 6'd0, 16'd14, 16'd4, 8'h00, 8'd16, 16'hffff,
                               16'hffff, 32'd0, 16'd0}};
        rows[21] = '{mk_op(OP_NOP), 1, '0};
        rows[22] = '{mk_rsp(16'hffff, 16'd0, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0), 1, '0};
        rows[23] = '{mk_op(OP_TICK), 0, '0};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            track_word(rows[i].w, r);
            pending_results.push_back(rows[i].fixed ? rows[i].r : r);
            send_word(rows[i].w);
        end

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: setup(32'd2, 16'd3, 32'hc0a80001, 16'd502);
                1: setup(32'd1, 16'd0, 32'hffffffff, 16'hffff);
                2: setup(32'd0, 16'hffff, 32'd0, 16'd0);
                3: setup(32'd5, 16'd1, $urandom, 16'($urandom));
                4: setup(32'hffffffff, 16'd100, $urandom, 16'($urandom));
                default: setup(32'd3, 16'd2, 32'h0a000002, 16'd1502);
            endcase
            if (ph == 1) hold_go = 1;
            repeat (215) push_word(random_word());
        end

        // fill the table with words back to back
        drain();
        no_gaps = 1;
        for (int a = 0; tt_used < DEPTH; a++) push_word(mk_sub(8'd1, 8'd6, 16'(a), 16'hbeef));
        no_gaps = 0;
        repeat (40) push_word(random_word());

        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
            waited++;
            if (waited > 200000) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
        repeat (40) @(posedge i_clk);
        if (n_err == 0 && pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
